// ===== hw/rtl/sic_pkg.sv =====
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types, codes and width helpers for the segment intersection core.
// ----------------------------------------------------------------------------
package sic_pkg;

  // result class of one segment pair
  typedef enum logic [2:0] {
    HIT_BOTH     = 3'd0,
    HIT_A        = 3'd1,
    HIT_B        = 3'd2,
    HIT_LINES    = 3'd3,
    HIT_PARALLEL = 3'd4
  } hit_kind_e;

  // control that rides along with each word through the divider
  typedef struct packed {
    hit_kind_e kind;
    logic      neg_x;
    logic      neg_y;
  } sic_flags_t;

  localparam int POINT_WIDTH = 24;
  localparam int KIND_WIDTH  = 3;
  localparam int THR_WIDTH   = 16;
  localparam int CLAMP_WIDTH = 42;
  localparam longint QUOT_CLAMP = 64'sd1099511627776;
  localparam longint POINT_MAX  = 64'sd8388607;
  localparam longint POINT_MIN  = -64'sd8388608;

  // cross product width, capped at 64 bits
  function automatic int sic_mw(int w);
    return (2 * w + 3 > 64) ? 64 : 2 * w + 3;
  endfunction

  // numerator times delta width, capped at 64 bits
  function automatic int sic_pw(int w);
    return (sic_mw(w) + w + 1 > 64) ? 64 : sic_mw(w) + w + 1;
  endfunction

endpackage

// ===== hw/rtl/sic_front.sv =====
// ----------------------------------------------------------------------------
// sic_front
// Deltas, cross products, classification and point numerators (six stages).
// ----------------------------------------------------------------------------
module sic_front import sic_pkg::*; #(
  parameter int W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [8*W-1:0]            data_i,
  input  logic [THR_WIDTH-1:0]      thr_i,
  output logic                      valid_o,
  output sic_flags_t                flags_o,
  output logic [2*W-1:0]            base_o,
  output logic [sic_mw(W)-1:0]      div_o,
  output logic [sic_pw(W)-1:0]      num_x_o,
  output logic [sic_pw(W)-1:0]      num_y_o
);

  localparam int DW  = W + 1;
  localparam int PRW = 2 * W + 2;
  localparam int MW  = sic_mw(W);
  localparam int PW  = sic_pw(W);
  localparam int LH  = MW / 2;
  localparam int HW  = MW - LH;
  localparam int SW  = MW + DW + 1;

  // unpack the eight coordinates
  logic signed [W-1:0] c [8];
  for (genvar i = 0; i < 8; i++) begin : g_unpack
    assign c[i] = data_i[i*W +: W];
  end

  // stage 1: deltas
  logic                 v1_q;
  logic signed [DW-1:0] dxa1_q, dya1_q, dxb1_q, dyb1_q, ox1_q, oy1_q;
  logic signed [W-1:0]  ax1_q, ay1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxa1_q <= DW'(c[2]) - DW'(c[0]);
      dya1_q <= DW'(c[3]) - DW'(c[1]);
      dxb1_q <= DW'(c[6]) - DW'(c[4]);
      dyb1_q <= DW'(c[7]) - DW'(c[5]);
      ox1_q  <= DW'(c[0]) - DW'(c[4]);
      oy1_q  <= DW'(c[1]) - DW'(c[5]);
      ax1_q  <= c[0];
      ay1_q  <= c[1];
    end
  end

  // stage 2: six products
  logic                  v2_q;
  logic signed [PRW-1:0] pm1_q, pm2_q, pa1_q, pa2_q, pb1_q, pb2_q;
  logic signed [DW-1:0]  dxa2_q, dya2_q;
  logic signed [W-1:0]   ax2_q, ay2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm1_q  <= dyb1_q * dxa1_q;
      pm2_q  <= dxb1_q * dya1_q;
      pa1_q  <= dxb1_q * oy1_q;
      pa2_q  <= dyb1_q * ox1_q;
      pb1_q  <= dxa1_q * oy1_q;
      pb2_q  <= dya1_q * ox1_q;
      dxa2_q <= dxa1_q;
      dya2_q <= dya1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
    end
  end

  // stage 3: denominator and numerators
  logic signed [PRW:0]  m_full, la_full, lb_full;
  logic                 v3_q;
  logic signed [MW-1:0] m3_q, la3_q, lb3_q;
  logic signed [DW-1:0] dxa3_q, dya3_q;
  logic signed [W-1:0]  ax3_q, ay3_q;

  always_comb begin
    m_full  = (PRW+1)'(pm1_q) - (PRW+1)'(pm2_q);
    la_full = (PRW+1)'(pa1_q) - (PRW+1)'(pa2_q);
    lb_full = (PRW+1)'(pb1_q) - (PRW+1)'(pb2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m3_q   <= m_full[MW-1:0];
      la3_q  <= la_full[MW-1:0];
      lb3_q  <= lb_full[MW-1:0];
      dxa3_q <= dxa2_q;
      dya3_q <= dya2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
    end
  end

  // stage 4: classify, magnitude of denominator, partial products
  logic                     m_neg, on_a, on_b, par;
  logic [MW-1:0]            m_mag;
  hit_kind_e                kind_d;
  logic                     v4_q, mneg4_q;
  hit_kind_e                kind4_q;
  logic [MW-1:0]            mag4_q;
  logic signed [LH+DW:0]    xlo4_q, ylo4_q;
  logic signed [HW+DW-1:0]  xhi4_q, yhi4_q;
  logic signed [W-1:0]      ax4_q, ay4_q;

  always_comb begin
    m_neg = m3_q[MW-1];
    m_mag = m_neg ? MW'(-m3_q) : MW'(m3_q);
    par   = m_mag <= MW'(thr_i);
    if (!m_neg) begin
      on_a = (la3_q >= 0) && (la3_q <= m3_q);
      on_b = (lb3_q >= 0) && (lb3_q <= m3_q);
    end else begin
      on_a = (la3_q <= 0) && (la3_q >= m3_q);
      on_b = (lb3_q <= 0) && (lb3_q >= m3_q);
    end
    if (par)               kind_d = HIT_PARALLEL;
    else if (on_a && on_b) kind_d = HIT_BOTH;
    else if (on_a)         kind_d = HIT_A;
    else if (on_b)         kind_d = HIT_B;
    else                   kind_d = HIT_LINES;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind4_q <= kind_d;
      mneg4_q <= m_neg;
      mag4_q  <= m_mag;
      xlo4_q  <= $signed({1'b0, la3_q[LH-1:0]}) * dxa3_q;
      ylo4_q  <= $signed({1'b0, la3_q[LH-1:0]}) * dya3_q;
      xhi4_q  <= $signed(la3_q[MW-1:LH]) * dxa3_q;
      yhi4_q  <= $signed(la3_q[MW-1:LH]) * dya3_q;
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
    end
  end

  // stage 5: combine partial products
  logic signed [SW-1:0] sum_x, sum_y;
  logic                 v5_q, mneg5_q;
  hit_kind_e            kind5_q;
  logic [MW-1:0]        mag5_q;
  logic signed [PW-1:0] px5_q, py5_q;
  logic signed [W-1:0]  ax5_q, ay5_q;

  always_comb begin
    sum_x = (SW'(xhi4_q) <<< LH) + SW'(xlo4_q);
    sum_y = (SW'(yhi4_q) <<< LH) + SW'(ylo4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind5_q <= kind4_q;
      mneg5_q <= mneg4_q;
      mag5_q  <= mag4_q;
      px5_q   <= sum_x[PW-1:0];
      py5_q   <= sum_y[PW-1:0];
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;
    end
  end

  // stage 6: magnitudes and quotient signs
  logic v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en_i) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_o.kind  <= kind5_q;
      flags_o.neg_x <= px5_q[PW-1] ^ mneg5_q;
      flags_o.neg_y <= py5_q[PW-1] ^ mneg5_q;
      div_o         <= mag5_q;
      num_x_o       <= px5_q[PW-1] ? PW'(-px5_q) : PW'(px5_q);
      num_y_o       <= py5_q[PW-1] ? PW'(-py5_q) : PW'(py5_q);
      base_o        <= {ay5_q, ax5_q};
    end
  end

  assign valid_o = v6_q;

endmodule

// ===== hw/rtl/sic_div.sv =====
// ----------------------------------------------------------------------------
// sic_div
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module sic_div import sic_pkg::*; #(
  parameter int MW = 35,
  parameter int PW = 52,
  parameter int BW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  sic_flags_t    flags_i,
  input  logic [BW-1:0] base_i,
  input  logic [MW-1:0] div_i,
  input  logic [PW-1:0] num_x_i,
  input  logic [PW-1:0] num_y_i,
  output logic          valid_o,
  output sic_flags_t    flags_o,
  output logic [BW-1:0] base_o,
  output logic [PW-1:0] quot_x_o,
  output logic [PW-1:0] quot_y_o
);

  logic          v_q    [PW];
  sic_flags_t    fl_q   [PW];
  logic [BW-1:0] base_q [PW];
  logic [MW-1:0] d_q    [PW];
  logic [MW-1:0] rx_q   [PW];
  logic [MW-1:0] ry_q   [PW];
  logic [PW-1:0] nx_q   [PW];
  logic [PW-1:0] ny_q   [PW];
  logic [PW-1:0] qx_q   [PW];
  logic [PW-1:0] qy_q   [PW];

  for (genvar s = 0; s < PW; s++) begin : g_step
    logic          v_in;
    sic_flags_t    fl_in;
    logic [BW-1:0] base_in;
    logic [MW-1:0] d_in, rx_in, ry_in;
    logic [PW-1:0] nx_in, ny_in, qx_in, qy_in;
    logic [MW:0]   tx, ty;
    logic          gx, gy;

    // stage inputs: first stage from the front end
    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign fl_in   = flags_i;
      assign base_in = base_i;
      assign d_in    = div_i;
      assign rx_in   = '0;
      assign ry_in   = '0;
      assign nx_in   = num_x_i;
      assign ny_in   = num_y_i;
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign fl_in   = fl_q[s-1];
      assign base_in = base_q[s-1];
      assign d_in    = d_q[s-1];
      assign rx_in   = rx_q[s-1];
      assign ry_in   = ry_q[s-1];
      assign nx_in   = nx_q[s-1];
      assign ny_in   = ny_q[s-1];
      assign qx_in   = qx_q[s-1];
      assign qy_in   = qy_q[s-1];
    end

    // trial subtract for both lanes
    always_comb begin
      tx = {rx_in, nx_in[PW-1]};
      ty = {ry_in, ny_in[PW-1]};
      gx = tx >= {1'b0, d_in};
      gy = ty >= {1'b0, d_in};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_q[s]   <= fl_in;
        base_q[s] <= base_in;
        d_q[s]    <= d_in;
        rx_q[s]   <= gx ? MW'(tx - {1'b0, d_in}) : tx[MW-1:0];
        ry_q[s]   <= gy ? MW'(ty - {1'b0, d_in}) : ty[MW-1:0];
        nx_q[s]   <= nx_in << 1;
        ny_q[s]   <= ny_in << 1;
        qx_q[s]   <= {qx_in[PW-2:0], gx};
        qy_q[s]   <= {qy_in[PW-2:0], gy};
      end
    end
  end

  assign valid_o  = v_q[PW-1];
  assign flags_o  = fl_q[PW-1];
  assign base_o   = base_q[PW-1];
  assign quot_x_o = qx_q[PW-1];
  assign quot_y_o = qy_q[PW-1];

endmodule

// ===== hw/rtl/sic_back.sv =====
// ----------------------------------------------------------------------------
// sic_back
// Quotient sign, clamp, base offset and Q23.0 saturation into the output word
// (two stages).
// ----------------------------------------------------------------------------
module sic_back import sic_pkg::*; #(
  parameter int W  = 16,
  parameter int PW = 52
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  sic_flags_t                    flags_i,
  input  logic [2*W-1:0]                base_i,
  input  logic [PW-1:0]                 quot_x_i,
  input  logic [PW-1:0]                 quot_y_i,
  output logic                          valid_o,
  output hit_kind_e                     kind_o,
  output logic signed [POINT_WIDTH-1:0] x_o,
  output logic signed [POINT_WIDTH-1:0] y_o,
  output logic                          sat_o
);

  localparam int QW = (PW + 1 > 64) ? 64 : PW + 1;
  localparam int EW = (QW > CLAMP_WIDTH) ? QW : CLAMP_WIDTH;
  localparam int RW = EW + 1;
  localparam logic signed [EW-1:0] CLAMP_HI = EW'(QUOT_CLAMP);
  localparam logic signed [EW-1:0] CLAMP_LO = -CLAMP_HI;
  localparam logic signed [RW-1:0] SAT_HI   = RW'(POINT_MAX);
  localparam logic signed [RW-1:0] SAT_LO   = RW'(POINT_MIN);

  logic signed [PW:0]              sx, sy;
  logic signed [EW-1:0]            ex, ey, cx, cy;
  logic                            v_q;
  sic_flags_t                      fl_q;
  logic [2*W-1:0]                  base_q;
  logic signed [EW-1:0]            cx_q, cy_q;
  logic signed [RW-1:0]            rx, ry;
  logic signed [POINT_WIDTH-1:0]   ox, oy;
  logic                            satx, saty, par;

  // stage 1: signed quotient, wrapped to the working width, then clamped
  always_comb begin
    sx  = flags_i.neg_x ? -$signed({1'b0, quot_x_i}) : $signed({1'b0, quot_x_i});
    sy  = flags_i.neg_y ? -$signed({1'b0, quot_y_i}) : $signed({1'b0, quot_y_i});
    ex  = EW'($signed(sx[QW-1:0]));
    ey  = EW'($signed(sy[QW-1:0]));
    cx  = (ex > CLAMP_HI) ? CLAMP_HI : ((ex < CLAMP_LO) ? CLAMP_LO : ex);
    cy  = (ey > CLAMP_HI) ? CLAMP_HI : ((ey < CLAMP_LO) ? CLAMP_LO : ey);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_q   <= flags_i;
      base_q <= base_i;
      cx_q   <= cx;
      cy_q   <= cy;
    end
  end

  // stage 2: base offset and Q23.0 saturation
  always_comb begin
    rx  = RW'(cx_q) + RW'($signed(base_q[W-1:0]));
    ry  = RW'(cy_q) + RW'($signed(base_q[2*W-1:W]));
    satx = (rx > SAT_HI) || (rx < SAT_LO);
    saty = (ry > SAT_HI) || (ry < SAT_LO);
    ox  = (rx > SAT_HI) ? POINT_WIDTH'(SAT_HI) :
          ((rx < SAT_LO) ? POINT_WIDTH'(SAT_LO) : rx[POINT_WIDTH-1:0]);
    oy  = (ry > SAT_HI) ? POINT_WIDTH'(SAT_HI) :
          ((ry < SAT_LO) ? POINT_WIDTH'(SAT_LO) : ry[POINT_WIDTH-1:0]);
    par = fl_q.kind == HIT_PARALLEL;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_o <= fl_q.kind;
      x_o    <= par ? '0 : ox;
      y_o    <= par ? '0 : oy;
      sat_o  <= !par && (satx || saty);
    end
  end

endmodule

// ===== hw/rtl/segment_intersection_classify_core.sv =====
// Input words pass through the front end, the one-bit-per-stage divider and
// the back end, with every stage registered.
// Throughput: one word per cycle; the whole pipeline holds while the
// output word waits for m_axis_tready_i.
// Reset clears all valid bits and sets parallel_threshold to zero.
// ----------------------------------------------------------------------------
// segment_intersection_classify_core
// Segment pair intersection: hit class and saturated Q23.0 point.
// ----------------------------------------------------------------------------
module segment_intersection_classify_core import sic_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration: parallel_threshold
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [THR_WIDTH-1:0]     cfg_data_i,
  // input words
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_WIDTH-1:0] s_axis_tdata_i,
  // output words
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // point_x, point_y, point_saturated, zero fill
  output logic [55:0]              m_axis_tdata_o,
  // hit_kind
  output logic [KIND_WIDTH-1:0]    m_axis_tuser_o
);

  localparam int W  = COORD_WIDTH;
  localparam int MW = sic_mw(W);
  localparam int PW = sic_pw(W);

  logic                          en;
  logic [THR_WIDTH-1:0]          thr_q;
  logic                          f_valid, d_valid;
  sic_flags_t                    f_flags, d_flags;
  logic [2*W-1:0]                f_base, d_base;
  logic [MW-1:0]                 f_div;
  logic [PW-1:0]                 f_nx, f_ny, d_qx, d_qy;
  hit_kind_e                     o_kind;
  logic signed [POINT_WIDTH-1:0] o_x, o_y;
  logic                          o_sat;

  // pipeline moves unless the output word is held
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  sic_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .data_i  (s_axis_tdata_i),
    .thr_i   (thr_q),
    .valid_o (f_valid),
    .flags_o (f_flags),
    .base_o  (f_base),
    .div_o   (f_div),
    .num_x_o (f_nx),
    .num_y_o (f_ny)
  );

  sic_div #(.MW(MW), .PW(PW), .BW(2*W)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (f_valid),
    .flags_i  (f_flags),
    .base_i   (f_base),
    .div_i    (f_div),
    .num_x_i  (f_nx),
    .num_y_i  (f_ny),
    .valid_o  (d_valid),
    .flags_o  (d_flags),
    .base_o   (d_base),
    .quot_x_o (d_qx),
    .quot_y_o (d_qy)
  );

  sic_back #(.W(W), .PW(PW)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (d_valid),
    .flags_i  (d_flags),
    .base_i   (d_base),
    .quot_x_i (d_qx),
    .quot_y_i (d_qy),
    .valid_o  (m_axis_tvalid_o),
    .kind_o   (o_kind),
    .x_o      (o_x),
    .y_o      (o_y),
    .sat_o    (o_sat)
  );

  assign m_axis_tdata_o = {7'd0, o_sat, o_y, o_x};
  assign m_axis_tuser_o = o_kind;

  // parallel words carry a zero point
  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (o_kind == HIT_PARALLEL) |-> (m_axis_tdata_o[48:0] == '0))
    else $error("parallel word with nonzero point");

  // a held output word stops the input side
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");

  // saturation flag only with a coordinate at a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && o_sat |->
      (o_x == POINT_WIDTH'(POINT_MAX)) || (o_x == POINT_WIDTH'(POINT_MIN)) ||
      (o_y == POINT_WIDTH'(POINT_MAX)) || (o_y == POINT_WIDTH'(POINT_MIN)))
    else $error("saturation flag without clamped coordinate");

  // a configuration write lands in the threshold
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> thr_q == $past(cfg_data_i))
    else $error("threshold write lost");

endmodule

// ===== test/segment_intersection_classify_checker.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_classify_checker
// Watches the threshold, input and output channels of the segment intersection
// core, works out the hit class and saturated point of every accepted pair,
// and compares each output word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module segment_intersection_classify_checker import sic_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [127:0] s_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [55:0]  m_tdata_i,
  input  logic [2:0]   m_tuser_i,
  output int           errors_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    hit_kind_e          kind;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic               sat;
  } crossing_t;

  crossing_t        crossings_due[$];
  logic [15:0]      parallel_thr;
  int               word_count;

  // n/d within the closed unit interval, d nonzero
  function automatic bit param_in_unit(longint n, longint d);
    if (d > 0) return n >= 0 && n <= d;
    return n <= 0 && n >= d;
  endfunction

  // base + trunc(num*delta/m), clamped to Q23.0
  function automatic longint point_coord(longint base, longint num, longint delta,
                                         longint m, inout bit sat);
    longint p, q, r;
    p = num * delta;
    q = (m == -1) ? -p : p / m;
    if (q > QUOT_CLAMP) q = QUOT_CLAMP;
    if (q < -QUOT_CLAMP) q = -QUOT_CLAMP;
    r = base + q;
    if (r > POINT_MAX) begin
      sat = 1'b1;
      return POINT_MAX;
    end
    if (r < POINT_MIN) begin
      sat = 1'b1;
      return POINT_MIN;
    end
    return r;
  endfunction

  function automatic crossing_t predict_crossing(logic [127:0] w, logic [15:0] thr);
    longint c[8];
    longint dxa, dya, dxb, dyb, ox, oy, m, la, lb, mag;
    bit on_a, on_b, sat;
    crossing_t res;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(w[16*i +: 16]));
    dxa = c[2] - c[0];
    dya = c[3] - c[1];
    dxb = c[6] - c[4];
    dyb = c[7] - c[5];
    ox  = c[0] - c[4];
    oy  = c[1] - c[5];
    m   = dyb * dxa - dxb * dya;
    la  = dxb * oy - dyb * ox;
    lb  = dxa * oy - dya * ox;
    mag = (m < 0) ? -m : m;
    res = '0;
    if (mag <= longint'(thr)) begin
      res.kind = HIT_PARALLEL;
      return res;
    end
    on_a = param_in_unit(la, m);
    on_b = param_in_unit(lb, m);
    if (on_a && on_b) res.kind = HIT_BOTH;
    else if (on_a) res.kind = HIT_A;
    else if (on_b) res.kind = HIT_B;
    else res.kind = HIT_LINES;
    sat = 1'b0;
    res.px  = 24'(point_coord(c[0], la, dxa, m, sat));
    res.py  = 24'(point_coord(c[1], la, dya, m, sat));
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on output word %0d: %s got %0d, expected %0d",
             word_count, what, got, want);
    errors_o++;
  endtask

  // track the threshold, predict on input words, compare output words
  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t want;
    if (!rst_ni) begin
      parallel_thr = '0;
      crossings_due.delete();
      word_count = 0;
      pending_o = 0;
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) parallel_thr = cfg_data_i;
      if (s_tvalid_i && s_tready_i)
        crossings_due.push_back(predict_crossing(s_tdata_i, parallel_thr));
      if (m_tvalid_i && m_tready_i) begin
        if (crossings_due.size() == 0) begin
          report_mismatch("words outstanding", 0, 1);
        end else begin
          want = crossings_due.pop_front();
          if (m_tuser_i != want.kind)
            report_mismatch("hit_kind", m_tuser_i, want.kind);
          if (m_tdata_i[23:0] != want.px)
            report_mismatch("point_x", $signed(m_tdata_i[23:0]), want.px);
          if (m_tdata_i[47:24] != want.py)
            report_mismatch("point_y", $signed(m_tdata_i[47:24]), want.py);
          if (m_tdata_i[48] != want.sat)
            report_mismatch("point_saturated", m_tdata_i[48], want.sat);
          if (m_tdata_i[55:49] != '0)
            report_mismatch("fill bits", m_tdata_i[55:49], 0);
        end
        word_count++;
      end
      pending_o = crossings_due.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives segment pairs and threshold settings into the intersection core with
// random idling on both streams; the checker predicts and compares each word.
// ----------------------------------------------------------------------------
module tb import sic_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [55:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  int           errors;
  int           pending;
  bit           calm = 1'b0;
  int           stall_left = 0;

  localparam int DRAIN_CYCLES = 80;

  segment_intersection_classify_core dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  segment_intersection_classify_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid_i), .s_tready_i(s_axis_tready_o),
    .s_tdata_i(s_axis_tdata_i),
    .m_tvalid_i(m_axis_tvalid_o), .m_tready_i(m_axis_tready_i),
    .m_tdata_i(m_axis_tdata_o), .m_tuser_i(m_axis_tuser_o),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // output back-pressure in bursts
  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      m_axis_tready_i <= rst_ni;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  function automatic logic [127:0] pair_word(shortint ax0, shortint ay0, shortint ax1,
                                             shortint ay1, shortint bx0, shortint by0,
                                             shortint bx1, shortint by1);
    return {by1, bx1, by0, bx0, ay1, ax1, ay0, ax0};
  endfunction

  // random pair: mostly crossing-scale segments, some near parallel, some noise
  function automatic logic [127:0] random_pair();
    logic [127:0] w;
    shortint c[8];
    int span, mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      w = {$urandom, $urandom, $urandom, $urandom};
      return w;
    end
    span = (mode == 9) ? 32767 : (1 << $urandom_range(2, 13));
    for (int i = 0; i < 8; i++) c[i] = shortint'($urandom_range(0, 2 * span) - span);
    if (mode == 2 || mode == 3) begin
      // B follows A with a small tilt
      c[4] = c[0] + shortint'($urandom_range(0, 64) - 32);
      c[5] = c[1] + shortint'($urandom_range(0, 64) - 32);
      c[6] = c[4] + (c[2] - c[0]) + shortint'($urandom_range(0, 4) - 2);
      c[7] = c[5] + (c[3] - c[1]) + shortint'($urandom_range(0, 4) - 2);
    end
    return pair_word(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  task automatic send_pair(logic [127:0] w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // threshold change only once the core has drained
  task automatic set_threshold(logic [15:0] thr);
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] thr_plan[5];
    thr_plan = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 4096)), 16'd0};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset threshold of zero
    send_pair(pair_word(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_word(-256, -256, 256, 256, -256, 256, 256, -256));
    send_pair(pair_word(0, 0, 256, 0, 128, 256, 128, 512));
    send_pair(pair_word(0, 0, 256, 0, 512, -256, 512, 256));
    send_pair(pair_word(0, 0, 256, 0, 512, 256, 512, 512));
    send_pair(pair_word(0, 0, 256, 0, 0, -256, 0, 256));
    send_pair(pair_word(0, 0, 256, 0, 256, -256, 256, 256));
    send_pair(pair_word(0, 0, 256, 0, 128, 0, 128, 256));
    send_pair(pair_word(0, 0, 256, 0, 128, -256, 128, 0));
    send_pair(pair_word(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pair_word(0, 0, 32767, 1, 0, 256, 32767, 256));
    send_pair(pair_word(0, 0, 32767, -1, 0, -256, 32767, -256));
    send_pair(pair_word(0, 0, 1, 0, 0, 0, 0, -1));
    send_pair(pair_word(0, 0, 256, 256, 0, 256, 256, 512));
    send_pair(pair_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(pair_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(pair_word(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
    send_pair(pair_word(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair({4{32'hFFFF_FFFF}});

    // random phases over several thresholds, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      set_threshold(thr_plan[ph]);
      for (int i = 0; i < 306; i++) begin
        if (ph == 4 && i >= 150) calm = 1'b1;
        send_pair(random_pair());
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // run limit
  initial begin
    #(20ns * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
